FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/rlcs_pkg.sv
// ---------------------------------------------------------------------------
// rlcs_pkg
// Types, codes and helpers for the RGB LED chain serializer.
// ---------------------------------------------------------------------------
package rlcs_pkg;

  localparam int LED_COUNT_W   = 11;
  localparam int COLOUR_W      = 24;
  localparam int TICKS_W       = 16;
  localparam int BITS_PER_LED  = 24;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MAX_LEDS_DEF  = 1024;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_t;

  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_GAP = 3'd4;

  typedef struct packed {
    opcode_t                opcode;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [LED_COUNT_W-1:0] led_count;
  } in_word_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic start_refused;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                   is_start;
    logic [COLOUR_W-1:0]    colour;
    logic [LED_COUNT_W-1:0] count;
  } cmd_t;

  function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
    return (v == '0) ? TICKS_W'(1) : v;
  endfunction

endpackage

FILE: rtl/rgb_led_chain_serializer.sv
// ---------------------------------------------------------------------------
// rgb_led_chain_serializer
// Single-wire RGB LED chain driver, one word in and one word out per tick.
// ---------------------------------------------------------------------------
// Each input word is either a tick (one line clock passes) or a start that
// loads a GRB colour and an LED count; every word yields exactly one result
// word with the line level and status. Sustained rate is one word per clock
// while the output side is not stalled: the front classifies a word in the
// cycle it is taken, a two-entry queue holds it, and the back timing engine
// retires one queued word per cycle into the output register, so each word
// passes through a queue entry and then the output register. Timing registers
// are written through the cfg port, one write per cycle, take effect at once,
// and should only change while no words are in flight.
module rgb_led_chain_serializer
  import rlcs_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  in_word_t               item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_word_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  rlcs_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (fr_valid),
    .cmd_ready  (fr_ready),
    .cmd        (fr_cmd)
  );

  rlcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  rlcs_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (bk_valid),
    .cmd_ready    (bk_ready),
    .cmd          (bk_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

FILE: rtl/rlcs_queue.sv
// ---------------------------------------------------------------------------
// rlcs_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module rlcs_queue
  import rlcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/rlcs_front.sv
// ---------------------------------------------------------------------------
// rlcs_front
// Takes input words, decodes the opcode, packs the colour in GRB order and
// clamps the LED count.
// ---------------------------------------------------------------------------
module rlcs_front
  import rlcs_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic     item_valid,
  output logic     item_ready,
  input  in_word_t item,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic [LED_COUNT_W-1:0] count_sat;

  always_comb begin
    if (32'(item.led_count) > MAX_LEDS) begin
      count_sat = LED_COUNT_W'(MAX_LEDS);
    end else begin
      count_sat = item.led_count;
    end
  end

  assign item_ready   = cmd_ready;
  assign cmd_valid    = item_valid;
  assign cmd.is_start = (item.opcode == OP_START);
  assign cmd.colour   = {item.green, item.red, item.blue};
  assign cmd.count    = count_sat;

endmodule

FILE: rtl/rlcs_back.sv
// ---------------------------------------------------------------------------
// rlcs_back
// Line timing engine: bit phases, LED count, latch gap, timing registers and
// the output word register.
// ---------------------------------------------------------------------------
module rlcs_back
  import rlcs_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_word_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NEED_W = $clog2(MAX_LEDS + 1);
  localparam int CNT_W  = (NEED_W < LED_COUNT_W) ? NEED_W : LED_COUNT_W;
  localparam int IDX_W  = $clog2(BITS_PER_LED);

  logic [7:0]         zero_high_ticks;
  logic [7:0]         zero_low_ticks;
  logic [7:0]         one_high_ticks;
  logic [7:0]         one_low_ticks;
  logic [TICKS_W-1:0] latch_gap_ticks;

  phase_t              phase, phase_next;
  logic [COLOUR_W-1:0] colour_word, colour_word_next;
  logic [COLOUR_W-1:0] bit_shift, bit_shift_next;
  logic [IDX_W-1:0]    bit_index, bit_index_next;
  logic [CNT_W-1:0]    leds_left, leds_left_next;
  logic [TICKS_W-1:0]  phase_ticks, phase_ticks_next;

  logic                take;
  out_word_t           res;
  logic [TICKS_W-1:0]  ticks_dec;
  logic [COLOUR_W-1:0] shifted;
  logic [CNT_W-1:0]    leds_dec;
  logic [CNT_W-1:0]    start_cnt;

  function automatic logic [TICKS_W-1:0] high_len(input logic b, input logic [7:0] one_t,
                                                  input logic [7:0] zero_t);
    return at_least_one(TICKS_W'(b ? one_t : zero_t));
  endfunction

  assign cfg_ready = 1'b1;
  assign cmd_ready = !result_valid || result_ready;
  assign take      = cmd_valid && cmd_ready;
  assign ticks_dec = phase_ticks - TICKS_W'(1);
  assign shifted   = {bit_shift[COLOUR_W-2:0], 1'b0};
  assign leds_dec  = (leds_left != '0) ? leds_left - CNT_W'(1) : leds_left;
  assign start_cnt = cmd.count[CNT_W-1:0];

  always_comb begin
    phase_next       = phase;
    colour_word_next = colour_word;
    bit_shift_next   = bit_shift;
    bit_index_next   = bit_index;
    leds_left_next   = leds_left;
    phase_ticks_next = phase_ticks;
    res              = '0;
    if (take) begin
      if (cmd.is_start) begin
        res.busy_res = 1'b1;
        if (phase != PH_IDLE) begin
          res.start_refused = 1'b1;
          res.pin_level     = (phase == PH_HIGH);
        end else begin
          colour_word_next = cmd.colour;
          bit_shift_next   = cmd.colour;
          bit_index_next   = '0;
          leds_left_next   = start_cnt;
          if (start_cnt != '0) begin
            phase_next       = PH_HIGH;
            phase_ticks_next = high_len(cmd.colour[COLOUR_W-1], one_high_ticks,
                                        zero_high_ticks);
            res.pin_level    = 1'b1;
          end else begin
            phase_next       = PH_LATCH;
            phase_ticks_next = at_least_one(latch_gap_ticks);
          end
        end
      end else if (phase != PH_IDLE) begin
        res.busy_res     = 1'b1;
        res.pin_level    = (phase == PH_HIGH);
        phase_ticks_next = ticks_dec;
        if (ticks_dec == '0) begin
          case (phase)
            PH_HIGH: begin
              phase_next       = PH_LOW;
              phase_ticks_next = high_len(bit_shift[COLOUR_W-1], one_low_ticks,
                                          zero_low_ticks);
            end
            PH_LOW: begin
              if (bit_index == IDX_W'(BITS_PER_LED - 1)) begin
                // last bit of this LED: reload colour, next LED or latch
                bit_index_next = '0;
                bit_shift_next = colour_word;
                leds_left_next = leds_dec;
                if (leds_dec == '0) begin
                  phase_next       = PH_LATCH;
                  phase_ticks_next = at_least_one(latch_gap_ticks);
                end else begin
                  phase_next       = PH_HIGH;
                  phase_ticks_next = high_len(colour_word[COLOUR_W-1], one_high_ticks,
                                              zero_high_ticks);
                end
              end else begin
                bit_index_next   = bit_index + IDX_W'(1);
                bit_shift_next   = shifted;
                phase_next       = PH_HIGH;
                phase_ticks_next = high_len(shifted[COLOUR_W-1], one_high_ticks,
                                            zero_high_ticks);
              end
            end
            PH_LATCH: begin
              phase_next     = PH_IDLE;
              res.frame_done = 1'b1;
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      colour_word <= '0;
      bit_shift   <= '0;
      bit_index   <= '0;
      leds_left   <= '0;
      phase_ticks <= '0;
    end else begin
      phase       <= phase_next;
      colour_word <= colour_word_next;
      bit_shift   <= bit_shift_next;
      bit_index   <= bit_index_next;
      leds_left   <= leds_left_next;
      phase_ticks <= phase_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_ticks <= 8'd20;
      zero_low_ticks  <= 8'd43;
      one_high_ticks  <= 8'd40;
      one_low_ticks   <= 8'd23;
      latch_gap_ticks <= 16'd4000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[7:0];
        REG_ZERO_LOW:  zero_low_ticks  <= cfg_data[7:0];
        REG_ONE_HIGH:  one_high_ticks  <= cfg_data[7:0];
        REG_ONE_LOW:   one_low_ticks   <= cfg_data[7:0];
        REG_LATCH_GAP: latch_gap_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule

FILE: rtl/rlcs_checker.sv
// ---------------------------------------------------------------------------
// rlcs_checker
// Port-level checks on the serializer's result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rlcs_checker
  import rlcs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input out_word_t result
);

  // a stalled result word holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  // the line only goes high inside a frame
  `ASSERT_IMPLY(a_pin_busy, clk, rst, result_valid && result.pin_level, result.busy_res)

  // frame end is reported while still busy, and never with a refusal
  `ASSERT_IMPLY(a_done_busy, clk, rst, result_valid && result.frame_done, result.busy_res && !result.start_refused)

  // a refused start only happens inside a frame
  `ASSERT_IMPLY(a_refused_busy, clk, rst, result_valid && result.start_refused, result.busy_res)

endmodule

bind rgb_led_chain_serializer rlcs_checker u_rlcs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: tb/sv/led_line_tracker_pkg.sv
// ---------------------------------------------------------------------------
// led_line_tracker_pkg
// Tracks the LED line timing state and predicts the result word for every
// accepted input word, then checks result words against those predictions
// in order.
// ---------------------------------------------------------------------------
package led_line_tracker_pkg;
  import rlcs_pkg::*;

  class led_line_tracker;
    bit [7:0]    zero_high, zero_low, one_high, one_low;
    bit [15:0]   latch_gap;
    bit [23:0]   colour, shifter;
    int unsigned bit_pos;
    bit [10:0]   leds_left;
    phase_t      phase;
    bit [15:0]   ticks_left;
    out_word_t   due_results[$];
    int unsigned faults, reported, seen;

    function new();
      zero_high = 8'd20;
      zero_low = 8'd43;
      one_high = 8'd40;
      one_low = 8'd23;
      latch_gap = 16'd4000;
      colour = '0;
      shifter = '0;
      bit_pos = 0;
      leds_left = '0;
      phase = PH_IDLE;
      ticks_left = '0;
      faults = 0;
      reported = 0;
      seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ZERO_HIGH: zero_high = data[7:0];
        REG_ZERO_LOW:  zero_low = data[7:0];
        REG_ONE_HIGH:  one_high = data[7:0];
        REG_ONE_LOW:   one_low = data[7:0];
        REG_LATCH_GAP: latch_gap = data;
        default: ;
      endcase
    endfunction

    // a zero tick count behaves as one tick
    function bit [15:0] or_one(bit [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function void start_pulse();
      phase = PH_HIGH;
      ticks_left = or_one(shifter[23] ? one_high : zero_high);
    endfunction

    function void start_latch();
      phase = PH_LATCH;
      ticks_left = or_one(latch_gap);
    endfunction

    function void accept_word(in_word_t w);
      out_word_t e;
      e = '0;
      if (w.opcode == OP_START) begin
        if (phase != PH_IDLE) begin
          e.start_refused = 1'b1;
        end else begin
          colour = {w.green, w.red, w.blue};
          shifter = colour;
          bit_pos = 0;
          leds_left = (w.led_count > MAX_LEDS_DEF) ? 11'(MAX_LEDS_DEF) : w.led_count;
          if (leds_left != 0) start_pulse();
          else start_latch();
        end
        e.pin_level = (phase == PH_HIGH);
        e.busy_res = (phase != PH_IDLE);
      end else if (phase != PH_IDLE) begin
        e.pin_level = (phase == PH_HIGH);
        e.busy_res = 1'b1;
        ticks_left = ticks_left - 16'd1;
        if (ticks_left == 16'd0) begin
          case (phase)
            PH_HIGH: begin
              phase = PH_LOW;
              ticks_left = or_one(shifter[23] ? one_low : zero_low);
            end
            PH_LOW: begin
              shifter = shifter << 1;
              bit_pos++;
              if (bit_pos >= BITS_PER_LED) begin
                // next LED gets the same colour again
                bit_pos = 0;
                shifter = colour;
                if (leds_left != 0) leds_left--;
                if (leds_left == 0) start_latch();
                else start_pulse();
              end else begin
                start_pulse();
              end
            end
            default: begin
              phase = PH_IDLE;
              e.frame_done = 1'b1;
            end
          endcase
        end
      end
      due_results.push_back(e);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      bit bad;
      seen++;
      if (due_results.size() == 0) begin
        faults++;
        if (reported < 10) begin
          reported++;
          $display("result %0d: no word expected, got pin=%b busy=%b done=%b refused=%b",
                   seen, got.pin_level, got.busy_res, got.frame_done, got.start_refused);
        end
        return;
      end
      want = due_results.pop_front();
      bad = (got.pin_level !== want.pin_level) || (got.busy_res !== want.busy_res) ||
            (got.frame_done !== want.frame_done) ||
            (got.start_refused !== want.start_refused);
      if (bad) begin
        faults++;
        if (reported < 10) begin
          reported++;
          $display("result %0d: expected pin=%b busy=%b done=%b refused=%b", seen,
                   want.pin_level, want.busy_res, want.frame_done, want.start_refused);
          $display("result %0d:   actual pin=%b busy=%b done=%b refused=%b", seen,
                   got.pin_level, got.busy_res, got.frame_done, got.start_refused);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction
  endclass

endpackage

FILE: tb/sv/rgb_led_chain_serializer_test.sv
// ---------------------------------------------------------------------------
// rgb_led_chain_serializer_test
// Drives tick and start words into the LED chain serializer with random
// gaps on both handshakes, checks every result word against a tracked line
// state, and walks several timing register settings including zero and
// truncated values.
// ---------------------------------------------------------------------------
module rgb_led_chain_serializer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlcs_pkg::*;
  import led_line_tracker_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  in_word_t               item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  out_word_t              result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  led_line_tracker board = new();
  bit              calm = 1'b0;
  int unsigned     cycles = 0;

  rgb_led_chain_serializer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w.opcode = OP_TICK;
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    w.led_count = LED_COUNT_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t start_word(int unsigned count);
    in_word_t w;
    w = tick_word();
    w.opcode = OP_START;
    w.led_count = LED_COUNT_W'(count);
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    board.accept_word(w);
  endtask

  task automatic drain_frame();
    while (!board.idle()) send_word(tick_word());
  endtask

  // drop valid and wait until every expected word has come back
  task automatic settle();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(int unsigned zh, int unsigned zl, int unsigned oh,
                            int unsigned ol, int unsigned lg);
    write_reg(REG_ZERO_HIGH, CFG_DATA_W'(zh));
    write_reg(REG_ZERO_LOW, CFG_DATA_W'(zl));
    write_reg(REG_ONE_HIGH, CFG_DATA_W'(oh));
    write_reg(REG_ONE_LOW, CFG_DATA_W'(ol));
    write_reg(REG_LATCH_GAP, CFG_DATA_W'(lg));
  endtask

  // result side
  initial begin
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && !rst));
      board.check_word(result);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_word_t    w;
    int unsigned sent;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset timing values on one LED: first high pulse and start of its low
    // time, then the rest of the frame runs on the shortest timing
    send_word(tick_word());
    w = start_word(1);
    w.green = 8'hFF;
    w.red = 8'h00;
    w.blue = 8'h5A;
    send_word(w);
    w = tick_word();
    w.opcode = OP_START;
    send_word(w);
    calm = 1'b1;
    repeat (42) send_word(tick_word());
    calm = 1'b0;
    settle();
    set_timing(1, 1, 1, 1, 1);
    drain_frame();
    send_word(tick_word());
    send_word(tick_word());

    // shortest timing: latch only, all-ones colour, zero colour on two LEDs
    settle();
    set_timing(1, 1, 1, 1, 1);
    send_word(start_word(0));
    drain_frame();
    w = start_word(1);
    w.green = 8'hFF;
    w.red = 8'hFF;
    w.blue = 8'hFF;
    send_word(w);
    send_word(tick_word());
    w = start_word(2047);
    send_word(w);
    drain_frame();
    w = start_word(2);
    w.green = 8'h00;
    w.red = 8'h00;
    w.blue = 8'h00;
    send_word(w);
    drain_frame();

    // zero and truncated register values, then writes to unused indexes
    settle();
    write_reg(REG_ZERO_HIGH, 16'h0000);
    write_reg(REG_ZERO_LOW, 16'h0100);
    write_reg(REG_ONE_HIGH, 16'hFF00);
    write_reg(REG_ONE_LOW, 16'h0002);
    write_reg(REG_LATCH_GAP, 16'h0000);
    for (int i = int'(REG_LATCH_GAP) + 1; i < (1 << CFG_INDEX_W); i++)
      write_reg(CFG_INDEX_W'(i), 16'hFFFF);
    w = start_word(1);
    w.green = 8'h55;
    w.red = 8'hAA;
    w.blue = 8'h33;
    send_word(w);
    send_word(tick_word());
    drain_frame();

    // random frames under several short timing settings
    sent = 0;
    for (int s = 0; s < 4; s++) begin
      settle();
      if (s == 0)
        set_timing(1, 1, 1, 1, 1);
      else
        set_timing($urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 2),
                   $urandom_range(1, 2), $urandom_range(1, 12));
      while (sent < (s + 1) * 60) begin
        calm = ($urandom_range(0, 3) == 0);
        send_word(start_word($urandom_range(0, 2)));
        sent++;
        while (!board.idle()) begin
          w = tick_word();
          // occasional start while the frame is still running
          if ($urandom_range(0, 15) == 0) w.opcode = OP_START;
          send_word(w);
          sent++;
        end
        repeat ($urandom_range(0, 3)) begin
          send_word(tick_word());
          sent++;
        end
      end
    end
    calm = 1'b0;

    settle();
    repeat (4) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: rgb_led_chain_serializer.f
+incdir+rtl
rtl/rlcs_pkg.sv
rtl/rlcs_queue.sv
rtl/rlcs_front.sv
rtl/rlcs_back.sv
rtl/rgb_led_chain_serializer.sv
rtl/rlcs_checker.sv
tb/sv/led_line_tracker_pkg.sv
tb/sv/rgb_led_chain_serializer_test.sv
